[rtl/aicc_pkg.sv]
// Package for the animated-image container checker.
// Holds the parse phase encoding, role and status codes, the result record
// and small arithmetic helpers. No dependencies.
package aicc_pkg;

    // Width of the file offset counter; it saturates at its largest value.
    localparam int OFFSET_BITS = 64;
    localparam logic [63:0] OFFSET_MAX = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - OFFSET_BITS);

    // Fixed container constants
    localparam logic [7:0]  ID_HEADER   = 8'd1;
    localparam logic [7:0]  ID_CREDITS  = 8'd2;
    localparam logic [7:0]  ID_ANIM     = 8'd3;
    localparam logic [63:0] HDR_SIZE    = 64'd20;
    localparam logic [63:0] MIN_FILE    = 64'd29;
    localparam logic [63:0] CREDITS_MIN = 64'd23;
    localparam logic [63:0] CREDITS_FIX = 64'd14;
    localparam logic [63:0] IMG_HDR_FIX = 64'd36;
    localparam logic [31:0] MAGIC_FILE  = 32'h4646_4143;
    localparam logic [31:0] MAGIC_IMAGE = 32'h4646_4943;
    localparam logic [7:0]  CHAR_NL     = 8'h0A;
    localparam logic [7:0]  CHAR_NUL    = 8'h00;

    // Parse phases, one-hot
    typedef enum logic [21:0] {
        PH_H_ID       = 22'h000001,
        PH_H_LEN      = 22'h000002,
        PH_H_MAGIC    = 22'h000004,
        PH_H_LEN2     = 22'h000008,
        PH_H_NUM      = 22'h000010,
        PH_C_ID       = 22'h000020,
        PH_C_LEN      = 22'h000040,
        PH_C_DATE     = 22'h000080,
        PH_C_CLEN     = 22'h000100,
        PH_C_CREATOR  = 22'h000200,
        PH_A_ID       = 22'h000400,
        PH_A_LEN      = 22'h000800,
        PH_A_DUR      = 22'h001000,
        PH_I_MAGIC    = 22'h002000,
        PH_I_HLEN     = 22'h004000,
        PH_I_CLEN     = 22'h008000,
        PH_I_W        = 22'h010000,
        PH_I_H        = 22'h020000,
        PH_I_CAPTION  = 22'h040000,
        PH_I_TAGS     = 22'h080000,
        PH_I_PIXELS   = 22'h100000,
        PH_DONE       = 22'h200000
    } t_phase;

    typedef enum logic [2:0] {
        ROLE_STRUCT    = 3'd0,
        ROLE_CREATOR   = 3'd1,
        ROLE_CAPTION   = 3'd2,
        ROLE_CAP_END   = 3'd3,
        ROLE_TAG       = 3'd4,
        ROLE_TAG_END   = 3'd5,
        ROLE_THUMB     = 3'd6,
        ROLE_IGNORED   = 3'd7
    } t_role;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_HEADER   = 3'd1,
        ST_CREDITS  = 3'd2,
        ST_ANIM     = 3'd3,
        ST_IMAGE    = 3'd4
    } t_status;

    // One result transaction
    typedef struct packed {
        logic [2:0]  byte_role;
        logic [7:0]  byte_value;
        logic [2:0]  status;
        logic        done_res;
        logic [15:0] year;
        logic [7:0]  month;
        logic [7:0]  day;
        logic [7:0]  hour;
        logic [7:0]  minute;
        logic [63:0] thumb_width;
        logic [63:0] thumb_height;
    } t_result;

    // a + b > lim, exact
    function automatic logic f_exceeds(input logic [63:0] a, input logic [63:0] b,
                                       input logic [63:0] lim);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s > {1'b0, lim};
    endfunction

    // Saturating 64-bit add
    function automatic logic [63:0] f_sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
    endfunction

endpackage

[rtl/aicc_ifs.sv]
// Channel interfaces of the container checker: byte input, result output
// and the file length write port. No dependencies.
interface aicc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first;
    modport source(output valid, data_byte, first, input ready);
    modport sink(input valid, data_byte, first, output ready);
endinterface

interface aicc_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  byte_role;
    logic [7:0]  byte_value;
    logic [2:0]  status;
    logic        done_res;
    logic [15:0] year;
    logic [7:0]  month;
    logic [7:0]  day;
    logic [7:0]  hour;
    logic [7:0]  minute;
    logic [63:0] thumb_width;
    logic [63:0] thumb_height;
    modport source(output valid, byte_role, byte_value, status, done_res, year, month, day,
                   hour, minute, thumb_width, thumb_height, input ready);
    modport sink(input valid, byte_role, byte_value, status, done_res, year, month, day,
                 hour, minute, thumb_width, thumb_height, output ready);
endinterface

interface aicc_cfg_if;
    logic        valid;
    logic        ready;
    logic [63:0] file_length;
    modport source(output valid, file_length, input ready);
    modport sink(input valid, file_length, output ready);
endinterface

[rtl/animated_image_container_checker_top.sv]
// Top level of the animated-image container checker: input register,
// parser core, result register and the file length register.
// Depends on aicc_pkg, aicc_ifs and aicc_parser.
//
//  channel  | dir | transaction payload
//  ---------+-----+----------------------------------------------------------
//  i_cfg    | in  | file_length (64)
//  i_in     | in  | data_byte (8), first (1)
//  o_res    | out | byte_role, byte_value, status, done_res, year, month, day,
//           |     | hour, minute, thumb_width, thumb_height
//
// One byte per cycle while results are taken; an accepted byte passes the input
// register, then the result register, before it shows up as a result.
// Reset is synchronous, active low; the file length resets to zero.
// A stalled result holds the result register; the input register still takes
// one more byte, then i_in.ready drops until the result is taken.
module animated_image_container_checker_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    aicc_cfg_if.sink    i_cfg,
    aicc_in_if.sink     i_in,
    aicc_out_if.source  o_res
);
    import aicc_pkg::*;

    logic [63:0] r_file_length;
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_first;
    logic        r_out_valid;
    t_result     r_out;
    t_result     step_res;
    logic        step;

    // Configuration register, always ready
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_file_length <= 64'd0;
        end else if (i_cfg.valid) begin
            r_file_length <= i_cfg.file_length;
        end
    end

    // Handshake: a byte moves into the result register when it is free
    assign step       = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_in.ready = !r_in_valid || step;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_byte  <= i_in.data_byte;
            r_in_first <= i_in.first;
        end
    end

    aicc_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_byte        (r_in_byte),
        .i_first       (r_in_first),
        .i_file_length (r_file_length),
        .o_res         (step_res)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end
    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= step_res;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.byte_role    = r_out.byte_role;
    assign o_res.byte_value   = r_out.byte_value;
    assign o_res.status       = r_out.status;
    assign o_res.done_res     = r_out.done_res;
    assign o_res.year         = r_out.year;
    assign o_res.month        = r_out.month;
    assign o_res.day          = r_out.day;
    assign o_res.hour         = r_out.hour;
    assign o_res.minute       = r_out.minute;
    assign o_res.thumb_width  = r_out.thumb_width;
    assign o_res.thumb_height = r_out.thumb_height;

    // Any error ends the check
    a_err_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status != ST_OK) |-> r_out.done_res)
        else $error("error status without final verdict");

    // Both registers full and result stalled: no new byte may enter
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !o_res.ready) |-> !i_in.ready)
        else $error("byte accepted while pipeline is full");

    // A stepped byte always produces a result next cycle
    a_step_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> r_out_valid)
        else $error("result lost");

endmodule

[rtl/aicc_parser.sv]
// Parser core: parse state registers and the one-byte next-state logic.
// Depends on aicc_pkg.
module aicc_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [7:0]       i_byte,
    input  logic             i_first,
    input  logic [63:0]      i_file_length,
    output aicc_pkg::t_result o_res
);
    import aicc_pkg::*;

    // State
    t_phase                 r_phase, n_phase;
    logic [3:0]             r_cnt, n_cnt;
    logic [63:0]            r_fs, n_fs;
    logic [OFFSET_BITS-1:0] r_off, n_off;
    logic [63:0]            r_anim, n_anim;
    logic [67:0]            r_anim9;
    logic [63:0]            r_blen, n_blen;
    logic [63:0]            r_ihl, n_ihl;
    logic [63:0]            r_clen, n_clen;
    logic [63:0]            r_fw, n_fw;
    logic [63:0]            r_fh, n_fh;
    logic [65:0]            r_w3;
    logic [63:0]            r_acc, n_acc;
    logic                   r_ovf, n_ovf;
    logic [63:0]            r_rend, n_rend;
    logic [2:0]             r_err, n_err;
    logic                   r_saved, n_saved;
    logic [47:0]            r_date, n_date;
    logic [63:0]            r_tw, n_tw;
    logic [63:0]            r_th, n_th;
    t_role                  role;

    // Helper: restart-adjusted current values
    t_phase                 c_phase;
    logic [3:0]             c_cnt;
    logic [OFFSET_BITS-1:0] c_off;
    logic [2:0]             c_err;
    logic [63:0]            c_anim;
    logic [67:0]            c_anim9;
    logic                   c_saved;

    // Collect / arithmetic
    logic [63:0]  fs_new;
    logic [3:0]   cnt_inc;
    logic [63:0]  off;
    logic [73:0]  prod;
    logic [137:0] shifted;
    logic [64:0]  acc_sum;
    logic [63:0]  acc_base;
    logic         ovf_base;
    logic         match;
    logic         closed;
    logic [63:0]  anim_dec;

    // Multiples used by later phases: anim*9 is registered from r_anim and is
    // read many bytes later; width*3 is loaded together with the width itself
    always_ff @(posedge i_clk) begin
        r_anim9 <= {4'b0, r_anim} + {1'b0, r_anim, 3'b000};
        if (i_step) begin
            r_w3 <= {2'b0, n_fw} + {1'b0, n_fw, 1'b0};
        end
    end

    // Restart view
    always_comb begin
        c_phase = i_first ? PH_H_ID : r_phase;
        c_cnt   = i_first ? 4'd0 : r_cnt;
        c_off   = i_first ? '0 : r_off;
        c_err   = i_first ? ST_OK : r_err;
        c_anim  = i_first ? 64'd0 : r_anim;
        c_anim9 = i_first ? 68'd0 : r_anim9;
        c_saved = i_first ? 1'b0 : r_saved;
    end

    // Byte collection and height product term
    always_comb begin
        fs_new   = ((c_cnt == 4'd0) ? 64'd0 : (i_first ? 64'd0 : r_fs))
                   | (64'(i_byte) << {c_cnt[2:0], 3'b000});
        cnt_inc  = c_cnt + 4'd1;
        acc_base = (c_cnt == 4'd0) ? 64'd0 : r_acc;
        ovf_base = (c_cnt == 4'd0) ? 1'b0 : r_ovf;
        prod     = r_w3 * i_byte;
        shifted  = {64'd0, prod} << {c_cnt[2:0], 3'b000};
        acc_sum  = {1'b0, acc_base} + {1'b0, shifted[63:0]};
        match    = !(ovf_base || (|shifted[137:64]) || acc_sum[64])
                   && (acc_sum[63:0] == r_clen);
        closed   = (i_byte == CHAR_NUL);
        anim_dec = c_anim - 64'd1;
    end

    // Next-state logic for one byte
    always_comb begin
        n_phase = c_phase;
        n_cnt   = c_cnt;
        n_fs    = i_first ? 64'd0 : r_fs;
        n_anim  = c_anim;
        n_blen  = i_first ? 64'd0 : r_blen;
        n_ihl   = i_first ? 64'd0 : r_ihl;
        n_clen  = i_first ? 64'd0 : r_clen;
        n_fw    = i_first ? 64'd0 : r_fw;
        n_fh    = i_first ? 64'd0 : r_fh;
        n_acc   = i_first ? 64'd0 : r_acc;
        n_ovf   = i_first ? 1'b0 : r_ovf;
        n_rend  = i_first ? 64'd0 : r_rend;
        n_err   = c_err;
        n_saved = c_saved;
        n_date  = i_first ? 48'd0 : r_date;
        n_tw    = i_first ? 64'd0 : r_tw;
        n_th    = i_first ? 64'd0 : r_th;
        role    = ROLE_STRUCT;

        // offset advance
        n_off = c_off;
        if (c_phase != PH_DONE && 64'(c_off) < OFFSET_MAX) begin
            n_off = c_off + OFFSET_BITS'(1);
        end
        off = 64'(n_off);

        // collecting phases update the shift register and counter
        if (c_phase inside {PH_H_LEN, PH_H_MAGIC, PH_H_LEN2, PH_H_NUM, PH_C_LEN, PH_C_DATE,
                            PH_C_CLEN, PH_A_LEN, PH_A_DUR, PH_I_MAGIC, PH_I_HLEN,
                            PH_I_CLEN, PH_I_W, PH_I_H}) begin
            n_fs = fs_new;
            n_cnt = cnt_inc;
        end

        case (c_phase)
            PH_H_ID: begin
                if (i_file_length < MIN_FILE || i_byte != ID_HEADER) begin
                    n_phase = PH_DONE; if (n_err == ST_OK) n_err = ST_HEADER;
                end else begin
                    n_phase = PH_H_LEN;
                end
            end
            PH_H_LEN, PH_H_LEN2: begin
                if (cnt_inc >= 4'd8) begin
                    n_cnt = 4'd0;
                    if (fs_new != HDR_SIZE) begin
                        n_phase = PH_DONE; if (n_err == ST_OK) n_err = ST_HEADER;
                    end else begin
                        n_phase = (c_phase == PH_H_LEN) ? PH_H_MAGIC : PH_H_NUM;
                    end
                end
            end
            PH_H_MAGIC: begin
                if (cnt_inc >= 4'd4) begin
                    n_cnt = 4'd0;
                    if (fs_new != 64'(MAGIC_FILE)) begin
                        n_phase = PH_DONE; if (n_err == ST_OK) n_err = ST_HEADER;
                    end else begin
                        n_phase = PH_H_LEN2;
                    end
                end
            end
            PH_H_NUM: begin
                if (cnt_inc >= 4'd8) begin
                    n_cnt  = 4'd0;
                    n_anim = fs_new;
                    if (f_exceeds(off, CREDITS_MIN, i_file_length)) begin
                        n_phase = PH_DONE; if (n_err == ST_OK) n_err = ST_CREDITS;
                    end else begin
                        n_phase = PH_C_ID;
                    end
                end
            end
            PH_C_ID: begin
                if (i_byte != ID_CREDITS) begin
                    n_phase = PH_DONE; if (n_err == ST_OK) n_err = ST_CREDITS;
                end else begin
                    n_phase = PH_C_LEN;
                end
            end
            PH_C_LEN: begin
                if (cnt_inc >= 4'd8) begin
                    n_cnt  = 4'd0;
                    n_blen = fs_new;
                    if (f_exceeds(off, fs_new, i_file_length)) begin
                        n_phase = PH_DONE; if (n_err == ST_OK) n_err = ST_CREDITS;
                    end else begin
                        n_phase = PH_C_DATE;
                    end
                end
            end
            PH_C_DATE: begin
                n_date = fs_new[47:0];
                if (cnt_inc >= 4'd6) begin
                    n_cnt   = 4'd0;
                    n_phase = PH_C_CLEN;
                end
            end
            PH_C_CLEN, PH_C_CREATOR: begin
                if (c_phase == PH_C_CREATOR) role = ROLE_CREATOR;
                if (c_phase == PH_C_CLEN && cnt_inc < 4'd8) begin
                    n_phase = c_phase;
                end else if (c_phase == PH_C_CLEN && (f_exceeds(off, fs_new, i_file_length)
                             || n_blen < CREDITS_FIX || n_blen - CREDITS_FIX != fs_new)) begin
                    n_cnt = 4'd0;
                    n_phase = PH_DONE; if (n_err == ST_OK) n_err = ST_CREDITS;
                end else begin
                    n_cnt = 4'd0;
                    if (c_phase == PH_C_CLEN) n_rend = off + fs_new;
                    if (off >= n_rend) begin
                        // enter the animation blocks
                        if (c_anim == 64'd0) begin
                            n_phase = PH_DONE;
                        end else if (off > i_file_length
                                     || c_anim9 > {4'b0, i_file_length - off}) begin
                            n_phase = PH_DONE; if (n_err == ST_OK) n_err = ST_ANIM;
                        end else begin
                            n_phase = PH_A_ID;
                        end
                    end else begin
                        n_phase = PH_C_CREATOR;
                    end
                end
            end
            PH_A_ID: begin
                if (i_byte != ID_ANIM) begin
                    n_phase = PH_DONE; if (n_err == ST_OK) n_err = ST_ANIM;
                end else begin
                    n_phase = PH_A_LEN;
                end
            end
            PH_A_LEN: begin
                if (cnt_inc >= 4'd8) begin
                    n_cnt  = 4'd0;
                    n_blen = fs_new;
                    if (f_exceeds(off, fs_new, i_file_length)) begin
                        n_phase = PH_DONE; if (n_err == ST_OK) n_err = ST_ANIM;
                    end else begin
                        n_phase = PH_A_DUR;
                    end
                end
            end
            PH_A_DUR: begin
                if (cnt_inc >= 4'd8) begin
                    n_cnt = 4'd0; n_phase = PH_I_MAGIC;
                end
            end
            PH_I_MAGIC: begin
                if (cnt_inc >= 4'd4) begin
                    n_cnt = 4'd0;
                    if (fs_new != 64'(MAGIC_IMAGE)) begin
                        n_phase = PH_DONE; if (n_err == ST_OK) n_err = ST_IMAGE;
                    end else begin
                        n_phase = PH_I_HLEN;
                    end
                end
            end
            PH_I_HLEN: begin
                if (cnt_inc >= 4'd8) begin
                    n_cnt = 4'd0; n_ihl = fs_new; n_phase = PH_I_CLEN;
                end
            end
            PH_I_CLEN: begin
                if (cnt_inc >= 4'd8) begin
                    n_cnt = 4'd0; n_clen = fs_new; n_phase = PH_I_W;
                end
            end
            PH_I_W: begin
                if (cnt_inc >= 4'd8) begin
                    n_cnt = 4'd0; n_fw = fs_new; n_phase = PH_I_H;
                end
            end
            PH_I_H: begin
                // width*3*height builds up one height byte at a time
                n_acc = acc_sum[63:0];
                n_ovf = ovf_base | (|shifted[137:64]) | acc_sum[64];
                if (cnt_inc >= 4'd8) begin
                    n_cnt = 4'd0;
                    n_fh  = fs_new;
                    if (!match || f_exceeds(off, n_clen, i_file_length)
                        || n_ihl > i_file_length || n_ihl < IMG_HDR_FIX) begin
                        n_phase = PH_DONE; if (n_err == ST_OK) n_err = ST_IMAGE;
                    end else begin
                        n_rend = f_sat_add(off, n_ihl - IMG_HDR_FIX);
                        if (f_sat_add(off, 64'd1) >= n_rend) begin
                            n_phase = PH_DONE; if (n_err == ST_OK) n_err = ST_IMAGE;
                        end else begin
                            n_phase = PH_I_CAPTION;
                        end
                    end
                end
            end
            PH_I_CAPTION: begin
                if (i_byte == CHAR_NL) begin
                    role = ROLE_CAP_END; n_phase = PH_I_TAGS;
                end else begin
                    role = ROLE_CAPTION;
                    if (f_sat_add(off, 64'd1) >= n_rend) begin
                        n_phase = PH_DONE; if (n_err == ST_OK) n_err = ST_IMAGE;
                    end
                end
            end
            PH_I_TAGS, PH_I_PIXELS: begin
                if (c_phase == PH_I_TAGS) role = closed ? ROLE_TAG_END : ROLE_TAG;
                else role = c_saved ? ROLE_IGNORED : ROLE_THUMB;
                if (off >= n_rend) begin
                    if (c_phase == PH_I_TAGS && !closed) begin
                        n_phase = PH_DONE; if (n_err == ST_OK) n_err = ST_IMAGE;
                    end else if (c_phase == PH_I_TAGS && n_clen != 64'd0) begin
                        n_rend  = f_sat_add(off, n_clen);
                        n_phase = PH_I_PIXELS;
                    end else begin
                        if (c_phase == PH_I_TAGS) n_rend = f_sat_add(off, n_clen);
                        if (c_phase == PH_I_PIXELS && !c_saved) begin
                            n_saved = 1'b1; n_tw = n_fw; n_th = n_fh;
                        end
                        // end of this animation block
                        n_anim = anim_dec;
                        if (anim_dec == 64'd0) begin
                            if (!n_saved) begin
                                n_phase = PH_DONE; if (n_err == ST_OK) n_err = ST_ANIM;
                            end else begin
                                n_phase = PH_DONE;
                            end
                        end else begin
                            n_phase = PH_A_ID;
                        end
                    end
                end
            end
            default: begin
                role    = ROLE_IGNORED;
                n_phase = PH_DONE;
            end
        endcase

        // early end of file: error of the block in progress
        if (n_phase != PH_DONE && off >= i_file_length) begin
            if (n_phase inside {PH_H_ID, PH_H_LEN, PH_H_MAGIC, PH_H_LEN2, PH_H_NUM}) begin
                if (n_err == ST_OK) n_err = ST_HEADER;
            end else if (n_phase inside {PH_C_ID, PH_C_LEN, PH_C_DATE, PH_C_CLEN,
                                         PH_C_CREATOR}) begin
                if (n_err == ST_OK) n_err = ST_CREDITS;
            end else if (n_phase inside {PH_A_ID, PH_A_LEN, PH_A_DUR}) begin
                if (n_err == ST_OK) n_err = ST_ANIM;
            end else begin
                if (n_err == ST_OK) n_err = ST_IMAGE;
            end
            n_phase = PH_DONE;
        end
    end

    // Result record
    always_comb begin
        o_res.byte_role    = role;
        o_res.byte_value   = i_byte;
        o_res.status       = n_err;
        o_res.done_res     = (n_phase == PH_DONE);
        o_res.year         = n_date[15:0];
        o_res.month        = n_date[23:16];
        o_res.day          = n_date[31:24];
        o_res.hour         = n_date[39:32];
        o_res.minute       = n_date[47:40];
        o_res.thumb_width  = n_tw;
        o_res.thumb_height = n_th;
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_H_ID;
            r_cnt   <= 4'd0;
            r_fs    <= 64'd0;
            r_off   <= '0;
            r_anim  <= 64'd0;
            r_blen  <= 64'd0;
            r_ihl   <= 64'd0;
            r_clen  <= 64'd0;
            r_fw    <= 64'd0;
            r_fh    <= 64'd0;
            r_acc   <= 64'd0;
            r_ovf   <= 1'b0;
            r_rend  <= 64'd0;
            r_err   <= ST_OK;
            r_saved <= 1'b0;
            r_date  <= 48'd0;
            r_tw    <= 64'd0;
            r_th    <= 64'd0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_fs    <= n_fs;
            r_off   <= n_off;
            r_anim  <= n_anim;
            r_blen  <= n_blen;
            r_ihl   <= n_ihl;
            r_clen  <= n_clen;
            r_fw    <= n_fw;
            r_fh    <= n_fh;
            r_acc   <= n_acc;
            r_ovf   <= n_ovf;
            r_rend  <= n_rend;
            r_err   <= n_err;
            r_saved <= n_saved;
            r_date  <= n_date;
            r_tw    <= n_tw;
            r_th    <= n_th;
        end
    end

endmodule

[verif/tb_animated_image_container_checker_top.sv]
// Self-checking testbench for animated_image_container_checker_top.
// Builds container files byte by byte, predicts each result with a scoreboard
// class. Depends on aicc_pkg, aicc_ifs and the top level RTL.
`timescale 1ns / 1ps

module tb_animated_image_container_checker_top;
    import aicc_pkg::*;

    // Tracks the parse of the current file and holds the results still owed
    class aicc_scoreboard;
        logic [63:0] file_len;
        t_phase      ph;
        int unsigned nbytes;
        logic [63:0] shift, offs, anims, blen, ihlen, clen, fw, fh, area, rend;
        logic [2:0]  err;
        bit          saved, closed;
        logic [47:0] date;
        logic [63:0] tw, th;
        t_result     owed[$];
        int          fails;

        function new();
            file_len = '0;
            fails = 0;
            clear();
        endfunction

        function void clear();
            ph = PH_H_ID; nbytes = 0; shift = '0; offs = '0; anims = '0; blen = '0;
            ihlen = '0; clen = '0; fw = '0; fh = '0; area = '0; rend = '0; err = ST_OK;
            saved = 0; closed = 0; date = '0; tw = '0; th = '0;
        endfunction

        function bit over(logic [63:0] a, logic [63:0] b, logic [63:0] lim);
            return (a > lim) || (b > lim - a);
        endfunction

        function logic [63:0] sadd(logic [63:0] a, logic [63:0] b);
            logic [64:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[64] ? '1 : s[63:0];
        endfunction

        function void raise(logic [2:0] code);
            if (err == ST_OK) err = code;
            ph = PH_DONE;
        endfunction

        function void goto(t_phase p);
            ph = p;
            nbytes = 0;
        endfunction

        // Little-endian field gather; true when n bytes are in
        function bit gather(logic [7:0] b, int unsigned n);
            if (nbytes == 0) shift = '0;
            shift |= {56'b0, b} << (8 * (nbytes & 7));
            nbytes++;
            if (nbytes >= n) begin
                nbytes = 0;
                return 1;
            end
            return 0;
        endfunction

        function void start_anims();
            if (anims == 0) goto(PH_DONE);
            else if (offs > file_len || anims > (file_len - offs) / 9) raise(ST_ANIM);
            else goto(PH_A_ID);
        endfunction

        function void close_anim();
            anims--;
            if (anims == 0) begin
                if (!saved) raise(ST_ANIM);
                else goto(PH_DONE);
            end else begin
                goto(PH_A_ID);
            end
        endfunction

        function bit area_ok();
            logic [63:0] max64;
            max64 = '1;
            if (fw != 0 && fh > max64 / fw) begin
                area = max64;
                return 0;
            end
            area = fw * fh;
            if (area > max64 / 3) return 0;
            return (area * 3) == clen;
        endfunction

        // Predict the result caused by one accepted byte
        function void note_input(logic [7:0] b, logic first);
            t_role   role;
            t_result r;
            role = ROLE_STRUCT;
            if (first) clear();
            if (ph != PH_DONE && offs < OFFSET_MAX) offs++;
            case (ph)
                PH_H_ID: if (file_len < MIN_FILE || b != ID_HEADER) raise(ST_HEADER);
                         else goto(PH_H_LEN);
                PH_H_LEN: if (gather(b, 8)) begin
                    if (shift != HDR_SIZE) raise(ST_HEADER); else goto(PH_H_MAGIC);
                end
                PH_H_MAGIC: if (gather(b, 4)) begin
                    if (shift != {32'b0, MAGIC_FILE}) raise(ST_HEADER); else goto(PH_H_LEN2);
                end
                PH_H_LEN2: if (gather(b, 8)) begin
                    if (shift != HDR_SIZE) raise(ST_HEADER); else goto(PH_H_NUM);
                end
                PH_H_NUM: if (gather(b, 8)) begin
                    anims = shift;
                    if (over(offs, CREDITS_MIN, file_len)) raise(ST_CREDITS);
                    else goto(PH_C_ID);
                end
                PH_C_ID: if (b != ID_CREDITS) raise(ST_CREDITS); else goto(PH_C_LEN);
                PH_C_LEN: if (gather(b, 8)) begin
                    blen = shift;
                    if (over(offs, blen, file_len)) raise(ST_CREDITS); else goto(PH_C_DATE);
                end
                PH_C_DATE: begin
                    if (gather(b, 6)) begin
                        date = shift[47:0];
                        goto(PH_C_CLEN);
                    end else begin
                        date = shift[47:0];
                    end
                end
                PH_C_CLEN: if (gather(b, 8)) begin
                    if (over(offs, shift, file_len) || blen < CREDITS_FIX
                        || blen - CREDITS_FIX != shift) begin
                        raise(ST_CREDITS);
                    end else begin
                        rend = offs + shift;
                        if (offs >= rend) start_anims(); else goto(PH_C_CREATOR);
                    end
                end
                PH_C_CREATOR: begin
                    role = ROLE_CREATOR;
                    if (offs >= rend) start_anims();
                end
                PH_A_ID: if (b != ID_ANIM) raise(ST_ANIM); else goto(PH_A_LEN);
                PH_A_LEN: if (gather(b, 8)) begin
                    blen = shift;
                    if (over(offs, blen, file_len)) raise(ST_ANIM); else goto(PH_A_DUR);
                end
                PH_A_DUR: if (gather(b, 8)) goto(PH_I_MAGIC);
                PH_I_MAGIC: if (gather(b, 4)) begin
                    if (shift != {32'b0, MAGIC_IMAGE}) raise(ST_IMAGE); else goto(PH_I_HLEN);
                end
                PH_I_HLEN: if (gather(b, 8)) begin ihlen = shift; goto(PH_I_CLEN); end
                PH_I_CLEN: if (gather(b, 8)) begin clen = shift; goto(PH_I_W); end
                PH_I_W: if (gather(b, 8)) begin fw = shift; goto(PH_I_H); end
                PH_I_H: if (gather(b, 8)) begin
                    fh = shift;
                    if (!area_ok() || over(offs, clen, file_len) || ihlen > file_len
                        || ihlen < IMG_HDR_FIX) begin
                        raise(ST_IMAGE);
                    end else begin
                        rend = sadd(offs, ihlen - IMG_HDR_FIX);
                        if (sadd(offs, 1) >= rend) raise(ST_IMAGE); else goto(PH_I_CAPTION);
                    end
                end
                PH_I_CAPTION: begin
                    if (b == CHAR_NL) begin
                        role = ROLE_CAP_END;
                        goto(PH_I_TAGS);
                    end else begin
                        role = ROLE_CAPTION;
                        if (sadd(offs, 1) >= rend) raise(ST_IMAGE);
                    end
                end
                PH_I_TAGS: begin
                    closed = (b == CHAR_NUL);
                    role = closed ? ROLE_TAG_END : ROLE_TAG;
                    if (offs >= rend) begin
                        if (!closed) raise(ST_IMAGE);
                        else begin
                            rend = sadd(offs, clen);
                            if (clen == 0) close_anim(); else goto(PH_I_PIXELS);
                        end
                    end
                end
                PH_I_PIXELS: begin
                    role = saved ? ROLE_IGNORED : ROLE_THUMB;
                    if (offs >= rend) begin
                        if (!saved) begin
                            saved = 1;
                            tw = fw;
                            th = fh;
                        end
                        close_anim();
                    end
                end
                default: begin
                    role = ROLE_IGNORED;
                    ph = PH_DONE;
                end
            endcase
            // file ran out before the check finished
            if (ph != PH_DONE && offs >= file_len) begin
                if (ph <= PH_H_NUM) raise(ST_HEADER);
                else if (ph <= PH_C_CREATOR) raise(ST_CREDITS);
                else if (ph <= PH_A_DUR) raise(ST_ANIM);
                else raise(ST_IMAGE);
            end
            r.byte_role = role;
            r.byte_value = b;
            r.status = err;
            r.done_res = (ph == PH_DONE);
            r.year = date[15:0];
            r.month = date[23:16];
            r.day = date[31:24];
            r.hour = date[39:32];
            r.minute = date[47:40];
            r.thumb_width = tw;
            r.thumb_height = th;
            owed.insert(owed.size(), r);
        endfunction

        function void cmp(string name, logic [63:0] e, logic [63:0] a);
            if (e !== a) begin
                $error("%s mismatch: expected %0h, got %0h", name, e, a);
                fails++;
            end
        endfunction

        function void check(t_result a);
            t_result e;
            if (owed.size() == 0) begin
                $error("result transaction with no prediction waiting");
                fails++;
                return;
            end
            e = owed.pop_front();
            cmp("byte_role", e.byte_role, a.byte_role);
            cmp("byte_value", e.byte_value, a.byte_value);
            cmp("status", e.status, a.status);
            cmp("done_res", e.done_res, a.done_res);
            cmp("year", e.year, a.year);
            cmp("month", e.month, a.month);
            cmp("day", e.day, a.day);
            cmp("hour", e.hour, a.hour);
            cmp("minute", e.minute, a.minute);
            cmp("thumb_width", e.thumb_width, a.thumb_width);
            cmp("thumb_height", e.thumb_height, a.thumb_height);
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    aicc_cfg_if cfg_if();
    aicc_in_if  in_if();
    aicc_out_if res_if();

    animated_image_container_checker_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if.sink),
        .i_in    (in_if.sink),
        .o_res   (res_if.source)
    );

    aicc_scoreboard sb = new();
    logic [7:0] fbytes[$];
    bit         quiet;
    int         sent;
    int         stall_left;

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    initial begin
        i_rst_n = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.file_length = '0;
        in_if.valid = 1'b0;
        in_if.data_byte = '0;
        in_if.first = 1'b0;
        res_if.ready = 1'b0;
    end

    // Gap lengths: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Result side: take and check, stall at random
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (res_if.valid && res_if.ready) begin
                sb.check({res_if.byte_role, res_if.byte_value, res_if.status,
                          res_if.done_res, res_if.year, res_if.month, res_if.day,
                          res_if.hour, res_if.minute, res_if.thumb_width,
                          res_if.thumb_height});
            end
            if (stall_left > 0) begin
                res_if.ready <= 1'b0;
                stall_left <= stall_left - 1;
            end else begin
                res_if.ready <= 1'b1;
                stall_left <= pick_gap();
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic first);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data_byte <= b;
        in_if.first <= first;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        sb.note_input(b, first);
        sent++;
    endtask

    task automatic drain();
        in_if.valid <= 1'b0;
        while (sb.owed.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // File length write, only once the checker has gone idle
    task automatic write_length(input logic [63:0] len);
        drain();
        cfg_if.valid <= 1'b1;
        cfg_if.file_length <= len;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        sb.file_len = len;
        cfg_if.valid <= 1'b0;
    endtask

    // Append one byte to the file under construction
    function automatic void put_byte(input logic [7:0] b);
        fbytes.insert(fbytes.size(), b);
    endfunction

    task automatic push_le(input logic [63:0] v, input int n);
        for (int i = 0; i < n; i++) put_byte(v[8*i +: 8]);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Container, well-formed unless huge_frame; without huge_frame, with_pixels 0 makes every frame empty
    task automatic build_file(input int n_anim, input bit with_pixels, input bit huge_frame);
        int cr_len, cap_len, tag_len;
        logic [63:0] w, h, cl;
        fbytes.delete();
        put_byte(ID_HEADER);
        push_le(HDR_SIZE, 8);
        push_le(MAGIC_FILE, 4);
        push_le(HDR_SIZE, 8);
        push_le(n_anim, 8);
        cr_len = $urandom_range(0, 4);
        put_byte(ID_CREDITS);
        push_le(CREDITS_FIX + cr_len, 8);
        push_le(rand64(), 6);
        push_le(cr_len, 8);
        repeat (cr_len) put_byte(8'($urandom_range(0, 255)));
        for (int a = 0; a < n_anim; a++) begin
            cap_len = $urandom_range(0, 3);
            tag_len = $urandom_range(1, 3);
            w = $urandom_range(0, 3);
            h = $urandom_range(0, 3);
            if (!with_pixels) w = 0;
            if (huge_frame) begin
                w = rand64();
                h = rand64();
            end
            cl = huge_frame ? rand64() : w * h * 3;
            put_byte(ID_ANIM);
            push_le(8 + IMG_HDR_FIX + cap_len + 1 + tag_len + (huge_frame ? 0 : cl), 8);
            push_le(rand64(), 8);
            push_le(MAGIC_IMAGE, 4);
            push_le(IMG_HDR_FIX + cap_len + 1 + tag_len, 8);
            push_le(cl, 8);
            push_le(w, 8);
            push_le(h, 8);
            repeat (cap_len) put_byte(8'($urandom_range(11, 255)));
            put_byte(CHAR_NL);
            repeat (tag_len - 1) put_byte(8'($urandom_range(0, 255)));
            put_byte(CHAR_NUL);
            if (!huge_frame) repeat (int'(cl)) put_byte(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic run_file(input logic [63:0] len);
        write_length(len);
        foreach (fbytes[i]) send_byte(fbytes[i], i == 0);
    endtask

    initial begin
        int kind;
        int idx;
        logic [63:0] len;
        sent = 0;
        stall_left = 0;
        quiet = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zero length file, bad header id, no animations with the
        // largest length, all frames empty, an oversized frame, a good file
        fbytes.delete();
        put_byte(ID_HEADER);
        run_file(64'd0);
        fbytes[0] = 8'hFF;
        run_file(64'd40);
        build_file(0, 1, 0);
        put_byte(8'h55);
        run_file('1);
        build_file(2, 0, 0);
        run_file(fbytes.size());
        build_file(1, 1, 1);
        run_file(fbytes.size());
        quiet = 1;
        build_file(2, 1, 0);
        run_file(fbytes.size());
        quiet = 0;

        // Random files: mostly well-formed, some broken, some noise
        while (sent < 1700) begin
            kind = $urandom_range(0, 99);
            quiet = ($urandom_range(0, 9) == 0);
            build_file($urandom_range(1, 3), 1, kind >= 96);
            len = fbytes.size();
            if (kind >= 70 && kind < 85) begin
                idx = $urandom_range(0, fbytes.size() - 1);
                fbytes[idx] = 8'($urandom_range(0, 255));
            end else if (kind >= 85 && kind < 90) begin
                len = len - $urandom_range(1, 20);
            end else if (kind >= 90 && kind < 93) begin
                len = ($urandom_range(0, 1)) ? '1 : len + $urandom_range(1, 9);
            end
            if (kind >= 93 && kind < 96) begin
                write_length(rand64() >> $urandom_range(0, 63));
                repeat ($urandom_range(5, 60))
                    send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 19) == 0);
            end else begin
                run_file(len);
            end
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (sb.fails == 0 && sb.owed.size() == 0) begin
            $display("tb_animated_image_container_checker_top OK");
        end else begin
            $display("tb_animated_image_container_checker_top NOT OK");
        end
        $finish;
    end

    initial begin
        #50_000_000;
        $display("tb_animated_image_container_checker_top NOT OK");
        $finish;
    end
endmodule
